/* rtl/core/feistel_sbox_block_cipher_assert.svh */
// Assertion helpers for the Feistel S-box cipher.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef FEISTEL_SBOX_BLOCK_CIPHER_ASSERT_SVH
`define FEISTEL_SBOX_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication.
`define FSBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FSBC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fsbc_pkg.sv */
package fsbc_pkg;

    localparam int WORD_W = 32;
    localparam int SBOX_N = 4;
    localparam int SEL_W  = 2;
    localparam int IDX_W  = 8;
    localparam int ROT_W  = 5;
    localparam int NSTAGE = 5;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PROC = 1'b1;

    localparam logic MODE_STD = 1'b0;
    localparam logic MODE_ALT = 1'b1;

    // Low-minus-high reduction of a 64-bit product, plus one on borrow.
    function automatic logic [WORD_W-1:0] mod_red(input logic [2*WORD_W-1:0] p);
        logic [WORD_W:0] diff;
        diff = {1'b0, p[WORD_W-1:0]} - {1'b0, p[2*WORD_W-1:WORD_W]};
        return diff[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, diff[WORD_W]};
    endfunction

    // Rotate left; a shift of zero returns the word unchanged.
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input logic [ROT_W-1:0] n);
        logic [2*WORD_W-1:0] w;
        w = {v, v} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

endpackage

/* rtl/core/fsbc_ram.sv */
module fsbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/feistel_sbox_block_cipher.sv */
// Channel   Ports                                              Handshake
// -------   -------------------------------------------------  -----------------------
// input     action table_select table_index table_word         start & !busy
//           left_in right_in
// result    left_out right_out                                 done, one cycle
// config    cfg_wdata (round_mode)                             cfg_we
//
// A block circles a five-stage ring once per round: S-box address, S-box data and
// multiply, reduction, round-function sum, combine and swap. Up to five blocks
// interleave; a new block enters only when no block returns from the last stage,
// so the ring takes a new block while others are still in flight.
// A block's result and done are registered after the swap of its final round.
// A load beat waits until the ring is empty, is written to its S-box, and holds
// busy meanwhile. Reset clears control only; the S-box memories get no clearing
// pass. The receiver cannot stall: done is a single-cycle strobe.
module feistel_sbox_block_cipher #(
    parameter int ROUND_COUNT = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [fsbc_pkg::SEL_W-1:0]     table_select,
    input  logic [fsbc_pkg::IDX_W-1:0]     table_index,
    input  logic [fsbc_pkg::WORD_W-1:0]    table_word,
    input  logic [fsbc_pkg::WORD_W-1:0]    left_in,
    input  logic [fsbc_pkg::WORD_W-1:0]    right_in,
    output logic                           done,
    output logic [fsbc_pkg::WORD_W-1:0]    left_out,
    output logic [fsbc_pkg::WORD_W-1:0]    right_out
);

    import fsbc_pkg::*;

    localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [RW-1:0] LAST_RND = RW'(ROUND_COUNT - 1);

    // Block context that travels around the ring.
    typedef struct packed {
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        logic [RW-1:0]     rnd;
    } ctx_t;

    logic              mode_reg;

    logic [NSTAGE-1:0] vld_reg, vld_next;
    ctx_t              ctx_reg  [NSTAGE];
    ctx_t              ctx_next [NSTAGE];

    // Pending load beat.
    logic              pend_reg, pend_next;
    logic [SEL_W-1:0]  pend_sel_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    logic [WORD_W-1:0] pend_word_reg;

    // Stage payloads.
    logic [2*WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0]   sum01_reg, sum01_next;
    logic [WORD_W-1:0]   s2w_reg, s2w_next;
    logic [WORD_W-1:0]   s3w_reg, s3w_next;
    logic [WORD_W-1:0]   sum23_reg, sum23_next;
    logic [WORD_W-1:0]   mred_reg, mred_next;
    logic [WORD_W-1:0]   stdf_reg, stdf_next;
    logic [WORD_W-1:0]   sum23b_reg, sum23b_next;
    logic [WORD_W-1:0]   f_reg, f_next;

    // Result register.
    logic              done_reg, done_next;
    logic [WORD_W-1:0] lout_reg, lout_next;
    logic [WORD_W-1:0] rout_reg, rout_next;

    logic              last;
    logic              ret;
    logic              accept;
    logic              wr_go;
    logic [WORD_W-1:0] new_left;
    ctx_t              ret_ctx;

    logic [WORD_W-1:0] sb_rdata [SBOX_N];
    logic [SBOX_N-1:0] ram_we;

    // S-box RAMs, one per box; read at a right-half byte, written at the load index.
    for (genvar k = 0; k < SBOX_N; k++)
    begin : g_sbox
        logic [IDX_W-1:0] addr;

        assign ram_we[k] = wr_go && (pend_sel_reg == SEL_W'(k));
        assign addr = wr_go ? pend_idx_reg
                            : ctx_reg[0].right[WORD_W-1-IDX_W*k -: IDX_W];

        fsbc_ram #(
            .WIDTH (WORD_W),
            .DEPTH (1 << IDX_W)
        ) u_ram (
            .clk   (clk),
            .we    (ram_we[k]),
            .addr  (addr),
            .wdata (pend_word_reg),
            .rdata (sb_rdata[k])
        );
    end

    assign last   = (ctx_reg[NSTAGE-1].rnd == LAST_RND);
    assign ret    = vld_reg[NSTAGE-1] && !last;
    assign busy   = pend_reg || ret;
    assign accept = start && !busy;
    // Write a load only when no block can still read the old word.
    assign wr_go  = pend_reg && (vld_reg == '0);

    always_comb
    begin
        // Stage 1: S-box words are here; multiply and pre-add.
        prod_next   = {{WORD_W{1'b0}}, sb_rdata[0]} * {{WORD_W{1'b0}}, sb_rdata[1]};
        sum01_next  = sb_rdata[0] + sb_rdata[1];
        s2w_next    = sb_rdata[2];
        s3w_next    = sb_rdata[3];
        sum23_next  = sb_rdata[2] + sb_rdata[3];

        // Stage 2: reduce the product, finish the standard function.
        mred_next   = mod_red(prod_reg);
        stdf_next   = (sum01_reg ^ s2w_reg) + s3w_reg;
        sum23b_next = sum23_reg;

        // Stage 3: pick the round function.
        f_next = (mode_reg == MODE_ALT) ? (mred_reg + sum23b_reg) : stdf_reg;

        // Stage 4: fold into the left half, then swap.
        if (mode_reg == MODE_ALT)
        begin
            new_left = ctx_reg[NSTAGE-1].left +
                       rotl(f_reg, ctx_reg[NSTAGE-1].right[ROT_W-1:0]);
        end
        else
        begin
            new_left = ctx_reg[NSTAGE-1].left ^ f_reg;
        end
        ret_ctx.left  = ctx_reg[NSTAGE-1].right;
        ret_ctx.right = new_left;
        ret_ctx.rnd   = ctx_reg[NSTAGE-1].rnd + RW'(1);

        done_next = vld_reg[NSTAGE-1] && last;
        lout_next = ret_ctx.left;
        rout_next = ret_ctx.right;

        // Advance the ring; a returning block has priority over a new beat.
        for (int s = 1; s < NSTAGE; s++)
        begin
            ctx_next[s] = ctx_reg[s-1];
            vld_next[s] = vld_reg[s-1];
        end
        if (ret)
        begin
            ctx_next[0] = ret_ctx;
            vld_next[0] = 1'b1;
        end
        else
        begin
            ctx_next[0].left  = left_in;
            ctx_next[0].right = right_in;
            ctx_next[0].rnd   = '0;
            vld_next[0]       = accept && (action == ACT_PROC);
        end

        pend_next = pend_reg;
        if (wr_go)
        begin
            pend_next = 1'b0;
        end
        if (accept && (action == ACT_LOAD))
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STD;
            vld_reg  <= '0;
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            vld_reg  <= vld_next;
            pend_reg <= pend_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NSTAGE; s++)
        begin
            ctx_reg[s] <= ctx_next[s];
        end
        if (accept && (action == ACT_LOAD))
        begin
            pend_sel_reg  <= table_select;
            pend_idx_reg  <= table_index;
            pend_word_reg <= table_word;
        end
        prod_reg   <= prod_next;
        sum01_reg  <= sum01_next;
        s2w_reg    <= s2w_next;
        s3w_reg    <= s3w_next;
        sum23_reg  <= sum23_next;
        mred_reg   <= mred_next;
        stdf_reg   <= stdf_next;
        sum23b_reg <= sum23b_next;
        f_reg      <= f_next;
        lout_reg   <= lout_next;
        rout_reg   <= rout_next;
    end

    assign done      = done_reg;
    assign left_out  = lout_reg;
    assign right_out = rout_reg;

`include "feistel_sbox_block_cipher_assert.svh"

    `FSBC_ASSERT_NOW(a_wr_ring_empty, ram_we != '0, vld_reg == '0,
        "S-box write while a block is in the ring")
    `FSBC_ASSERT_NXT(a_proc_enters, accept && (action == ACT_PROC), vld_reg[0],
        "accepted block missing from ring entry")
    `FSBC_ASSERT_NXT(a_load_pends, accept && (action == ACT_LOAD), pend_reg && busy,
        "accepted load beat not held")
    `FSBC_ASSERT_NOW(a_done_src, done_reg, $past(vld_reg[NSTAGE-1]) && $past(last),
        "result strobe without a final round")

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

// Checks the Feistel S-box cipher end to end.
// A scoreboard mirrors the four S-boxes and the round mode. It predicts left_out and
// right_out for every process beat without a typed result, at the edge where the beat
// is accepted. A monitor compares each done strobe, field by field, with the oldest expected block.
//
// Run order:
//   - write the mode register after reset,
//   - zero every S-box entry, since the RTL never clears them,
//   - walk a short table of directed beats,
//   - refill all entries with random words,
//   - run random phases, alternating the round mode between phases.
// No process beat is sent before every entry has been written, so a process beat
// never reads an undefined entry.
module tb;
    import fsbc_pkg::*;

    localparam int ROUND_COUNT  = 4;
    localparam int SETTLE       = 5 * ROUND_COUNT + 5;  // block latency plus margin
    localparam int STALL_LIMIT  = 400;                  // cycles with no beat and no done
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 150;
    localparam int QUIET_PHASE  = 3;                    // this phase never idles

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t left;
        word_t right;
    } block_t;

    typedef struct packed {
        logic             act;
        logic             mode;
        logic [SEL_W-1:0] sel;
        logic [IDX_W-1:0] idx;
        word_t            word;
        word_t            left;
        word_t            right;
        logic             typed;    // expected result typed in below, not predicted
        word_t            exp_left;
        word_t            exp_right;
    } plan_row_t;

    // While every S-box entry is zero, the round function is zero in both modes.
    // The halves then only swap, four times, so the block comes back unchanged.
    // Those rows carry their expected result. The rest go through the predictor.
    localparam plan_row_t PLAN [0:21] = '{
        '{ACT_PROC, MODE_STD, 2'd3, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
          1'b1, 32'h0000_0000, 32'h0000_0000},
        '{ACT_PROC, MODE_STD, 2'd0, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{ACT_PROC, MODE_STD, 2'd3, 8'd255, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
          1'b1, 32'h1234_5678, 32'h9ABC_DEF0},
        '{ACT_PROC, MODE_ALT, 2'd2, 8'd128, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
          1'b1, 32'hFFFF_FFFF, 32'h0000_0000},
        '{ACT_PROC, MODE_ALT, 2'd1, 8'd1, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
          1'b1, 32'h0000_0000, 32'hFFFF_FFFF},
        // Load extreme words at both ends of every box; the halves are ignored.
        '{ACT_LOAD, MODE_ALT, 2'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd1, 8'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd2, 8'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd3, 8'd0, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd0, 8'd255, 32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd1, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd2, 8'd255, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_ALT, 2'd3, 8'd255, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        // Alternate mode: a low byte of 0x00 or 0x20 gives a rotate by zero; 0x1F gives 31.
        '{ACT_PROC, MODE_ALT, 2'd0, 8'd0, 32'h0, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_ALT, 2'd3, 8'd255, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0020,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_ALT, 2'd0, 8'd0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_ALT, 2'd1, 8'd7, 32'h0, 32'h0000_0000, 32'h0000_001F,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_STD, 2'd0, 8'd0, 32'h0, 32'h0000_0000, 32'h0000_0000,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_STD, 2'd0, 8'd0, 32'h0, 32'hFFFF_FFFF, 32'hFF00_00FF,
          1'b0, 32'h0, 32'h0},
        '{ACT_LOAD, MODE_STD, 2'd2, 8'd128, 32'hA5A5_A5A5, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_STD, 2'd0, 8'd0, 32'h0, 32'h5A5A_5A5A, 32'h0000_8000,
          1'b0, 32'h0, 32'h0},
        '{ACT_PROC, MODE_ALT, 2'd0, 8'd0, 32'h0, 32'h0000_0000, 32'hFFFF_FF00,
          1'b0, 32'h0, 32'h0}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               start;
    logic               busy;
    logic               action;
    logic [SEL_W-1:0]   table_select;
    logic [IDX_W-1:0]   table_index;
    word_t              table_word;
    word_t              left_in;
    word_t              right_in;
    logic               done;
    word_t              left_out;
    word_t              right_out;

    // Scoreboard state: mirrored S-boxes, mode shadow, predicted blocks in flight.
    word_t  sbox_mirror [0:SBOX_N*256-1];
    logic   mode_shadow;
    block_t expected_blocks [$];
    int     fail_count;
    int     stall_cycles;
    bit     idling;

    feistel_sbox_block_cipher #(
        .ROUND_COUNT(ROUND_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .start(start),
        .busy(busy),
        .action(action),
        .table_select(table_select),
        .table_index(table_index),
        .table_word(table_word),
        .left_in(left_in),
        .right_in(right_in),
        .done(done),
        .left_out(left_out),
        .right_out(right_out)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Round function: index the four boxes with the bytes of the right half.
    function automatic word_t round_mix(input word_t r);
        word_t               s0, s1, s2, s3, lo, hi, red, sum;
        logic [2*WORD_W-1:0] prod;
        logic [ROT_W-1:0]    n;
        s0 = sbox_mirror[{2'd0, r[31:24]}];
        s1 = sbox_mirror[{2'd1, r[23:16]}];
        s2 = sbox_mirror[{2'd2, r[15:8]}];
        s3 = sbox_mirror[{2'd3, r[7:0]}];
        if (mode_shadow == MODE_STD)
            return ((s0 + s1) ^ s2) + s3;
        // Reduce the 64-bit product low minus high, and add back one on a borrow.
        prod = {{WORD_W{1'b0}}, s0} * {{WORD_W{1'b0}}, s1};
        lo   = prod[WORD_W-1:0];
        hi   = prod[2*WORD_W-1:WORD_W];
        red  = lo - hi;
        if (lo < hi)
            red = red + 1;
        sum = red + s2 + s3;
        n   = r[ROT_W-1:0];
        if (n == 0)
            return sum;
        return (sum << n) | (sum >> (WORD_W - n));
    endfunction

    function automatic block_t encipher(input word_t l, input word_t r);
        word_t f, t;
        for (int i = 0; i < ROUND_COUNT; i++)
        begin
            f = round_mix(r);
            t = (mode_shadow == MODE_STD) ? (l ^ f) : (l + f);
            l = r;
            r = t;
        end
        return {l, r};
    endfunction

    // Present one beat and hold it until an edge sees busy low. On acceptance,
    // update the mirror for a load, or queue the expected block for a process beat.
    task automatic send_beat(input plan_row_t b);
        start        <= 1'b1;
        action       <= b.act;
        table_select <= b.sel;
        table_index  <= b.idx;
        table_word   <= b.word;
        left_in      <= b.left;
        right_in     <= b.right;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (b.act == ACT_LOAD)
            sbox_mirror[{b.sel, b.idx}] = b.word;
        else if (b.typed)
            expected_blocks.push_back({b.exp_left, b.exp_right});
        else
            expected_blocks.push_back(encipher(b.left, b.right));
    endtask

    // Drop start about one beat in five, when idling is on.
    task automatic maybe_idle();
        if (idling && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // Hold off the sender until every expected block is out, then settle.
    // The do-while always advances to an edge first, so start is not driven twice in a step.
    task automatic drain(input int settle);
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_blocks.size() != 0);
        repeat (settle)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_we      <= 1'b1;
        cfg_wdata   <= m;
        mode_shadow = m;
        @(posedge clk);
        cfg_we      <= 1'b0;
    endtask

    function automatic word_t rand_word();
        word_t w;
        w = $urandom;
        // Bias toward the extremes now and then.
        if ($urandom_range(9) == 0)
            w = $urandom_range(1) ? '1 : '0;
        return w;
    endfunction

    function automatic plan_row_t rand_beat(input bit load);
        plan_row_t b;
        b.act       = load ? ACT_LOAD : ACT_PROC;
        b.mode      = mode_shadow;
        b.sel       = $urandom_range(SBOX_N - 1);
        b.idx       = $urandom_range(255);
        b.word      = rand_word();
        b.left      = rand_word();
        b.right     = rand_word();
        b.typed     = 1'b0;
        b.exp_left  = '0;
        b.exp_right = '0;
        return b;
    endfunction

    // Compare each done strobe with the oldest expected block.
    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && done)
        begin
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected block left_out %h right_out %h",
                         $time, left_out, right_out);
                fail_count++;
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (left_out !== want.left)
                begin
                    $display("%0t: left_out expected %h got %h", $time, want.left, left_out);
                    fail_count++;
                end
                if (right_out !== want.right)
                begin
                    $display("%0t: right_out expected %h got %h", $time, want.right, right_out);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when neither side moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[feistel_sbox_block_cipher] ERROR");
            $finish;
        end
    end

    initial
    begin
        plan_row_t b;
        fail_count   = 0;
        stall_cycles = 0;
        idling       = 1'b1;
        mode_shadow  = MODE_STD;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        start        = 1'b0;
        action       = ACT_LOAD;
        table_select = '0;
        table_index  = '0;
        table_word   = '0;
        left_in      = '0;
        right_in     = '0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write the mode register once after reset, then zero every entry so no
        // process beat can read a word that was never written.
        write_mode(MODE_STD);
        for (int e = 0; e < SBOX_N * 256; e++)
        begin
            b       = rand_beat(1'b1);
            b.sel   = e[9:8];
            b.idx   = e[7:0];
            b.word  = '0;
            send_beat(b);
            maybe_idle();
        end

        // Directed table: switch the mode only when the ring is empty.
        foreach (PLAN[i])
        begin
            if (PLAN[i].mode != mode_shadow)
            begin
                drain(SETTLE);
                write_mode(PLAN[i].mode);
            end
            send_beat(PLAN[i]);
            maybe_idle();
        end

        // Refill all entries with random words before the random phases.
        for (int e = 0; e < SBOX_N * 256; e++)
        begin
            b      = rand_beat(1'b1);
            b.sel  = e[9:8];
            b.idx  = e[7:0];
            b.word = $urandom;
            send_beat(b);
            maybe_idle();
        end

        // Random phases: drain and rewrite the mode between phases. One phase runs
        // back to back with no idling; the others now and then drain mid-phase.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            drain(SETTLE);
            write_mode((p % 2 == 0) ? MODE_ALT : MODE_STD);
            idling = (p != QUIET_PHASE);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_beat(rand_beat($urandom_range(3) == 0));
                if (idling && $urandom_range(99) < 2)
                    drain(0);
                else
                    maybe_idle();
            end
        end

        drain(SETTLE);
        if (fail_count == 0)
            $display("[feistel_sbox_block_cipher] OK");
        else
            $display("[feistel_sbox_block_cipher] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fsbc_pkg.sv
rtl/core/fsbc_ram.sv
rtl/core/feistel_sbox_block_cipher.sv
tb/sv/tb.sv
